@@ hw/rtl/range_sum_point_update_tree_unit_macros.svh @@
// Assertion macros used by the checker of the range sum tree unit.
// Each macro takes a label, a clock, a disable condition, and the two
// sides of an implication.
`ifndef RANGE_SUM_POINT_UPDATE_TREE_UNIT_MACROS_SVH
`define RANGE_SUM_POINT_UPDATE_TREE_UNIT_MACROS_SVH

// Same-cycle implication.
`define RSPUT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsput assertion failed");

// Next-cycle implication.
`define RSPUT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rsput assertion failed");

`endif

@@ hw/rtl/rsput_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range sum tree package
// Word formats and codes shared by the front end, the tree engine and the top.
// ----------------------------------------------------------------------------
package rsput_pkg;

   localparam int IDX_W = 10;
   localparam int VAL_W = 32;
   localparam int SUM_W = 42;
   localparam int CNT_W = 11;

   localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

   // Request kinds as they arrive on the input word.
   localparam logic REQ_SET = 1'b0;
   localparam logic REQ_SUM = 1'b1;

   // Command codes passed from the front end to the tree engine.
   typedef logic [1:0] cmd_op_type;
   localparam cmd_op_type CMD_SET  = 2'd0;
   localparam cmd_op_type CMD_SUM  = 2'd1;
   localparam cmd_op_type CMD_ZERO = 2'd2;

   typedef struct packed {
      cmd_op_type              op;
      logic [IDX_W-1:0]        lo;
      logic [IDX_W-1:0]        hi;
      logic signed [VAL_W-1:0] value;
   } cmd_type;

endpackage

@@ hw/rtl/range_sum_point_update_tree_unit.sv @@
// The engine takes one request at a time. A set walks leaf to root; a sum walks each tree
// level through a left-edge state and then a right-edge state, paced by the one read port.
// Reset: synchronous; afterwards a clearing pass zeroes all 2 * LEAF_COUNT tree nodes,
// with full held high. The element count register resets to 1024.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range sum tree unit
// Segment tree of partial sums with point set and inclusive range sum.
// ----------------------------------------------------------------------------
module range_sum_point_update_tree_unit #(
   parameter int LEAF_COUNT = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic                               req_type,
   input  logic [rsput_pkg::IDX_W-1:0]        req_first_index,
   input  logic [rsput_pkg::IDX_W-1:0]        req_last_index,
   input  logic signed [rsput_pkg::VAL_W-1:0] req_new_value,
   output logic                               empty,
   input  logic                               pop,
   output logic signed [rsput_pkg::SUM_W-1:0] rsp_range_sum,
   input  logic                               csr_wr_en,
   input  logic [rsput_pkg::CNT_W-1:0]        csr_wr_data
);
   import rsput_pkg::*;

   localparam int CMD_W = $bits(cmd_type);

   cmd_type          front_cmd;
   cmd_type          back_cmd;
   logic [CMD_W-1:0] back_cmd_word;
   logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic             clearing;
   logic             res_push, res_full;
   logic [SUM_W-1:0] res_word;
   logic [SUM_W-1:0] out_word;

   // Front end: count register and classification.
   rsput_front #(
      .LEAF_COUNT(LEAF_COUNT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_type        (req_type),
      .req_first_index (req_first_index),
      .req_last_index  (req_last_index),
      .req_new_value   (req_new_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .clearing        (clearing),
      .cmd_full        (cmd_full),
      .cmd_push        (cmd_push),
      .cmd_data        (front_cmd)
   );

   // Command queue between front end and engine.
   rsput_fifo #(
      .WIDTH(CMD_W),
      .DEPTH(2)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (front_cmd),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (back_cmd_word),
      .empty   (cmd_empty)
   );

   assign back_cmd = back_cmd_word;

   // Tree engine.
   rsput_back #(
      .LEAF_COUNT(LEAF_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (back_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (res_full),
      .rsp_push  (res_push),
      .rsp_data  (res_word),
      .clearing  (clearing)
   );

   // Result queue toward the consumer.
   rsput_fifo #(
      .WIDTH(SUM_W),
      .DEPTH(2)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (res_word),
      .full    (res_full),
      .pop     (pop),
      .rd_data (out_word),
      .empty   (empty)
   );

   assign rsp_range_sum = $signed(out_word);

endmodule

@@ hw/rtl/rsput_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small word queue
// Ring buffer of DEPTH words with full and empty flags; head word shown.
// ----------------------------------------------------------------------------
module rsput_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; only written slots are ever shown while not empty.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ hw/rtl/rsput_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range sum tree front end
// Holds the element count register, accepts request words and turns them
// into tree commands: drops out-of-range sets, clips and screens queries.
// ----------------------------------------------------------------------------
module rsput_front #(
   parameter int LEAF_COUNT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic                              req_type,
   input  logic [rsput_pkg::IDX_W-1:0]       req_first_index,
   input  logic [rsput_pkg::IDX_W-1:0]       req_last_index,
   input  logic signed [rsput_pkg::VAL_W-1:0] req_new_value,
   input  logic                              csr_wr_en,
   input  logic [rsput_pkg::CNT_W-1:0]       csr_wr_data,
   input  logic                              clearing,
   input  logic                              cmd_full,
   output logic                              cmd_push,
   output rsput_pkg::cmd_type                cmd_data
);
   import rsput_pkg::*;

   // Largest count that can matter at this tree size.
   localparam logic [CNT_W-1:0] COUNT_CAP =
      (LEAF_COUNT > 2047) ? {CNT_W{1'b1}} : CNT_W'(LEAF_COUNT);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] eff_count;
   logic [CNT_W-1:0] first_ext;
   logic [CNT_W-1:0] last_ext;
   logic [CNT_W-1:0] last_clip;
   logic             accept;

   // Element count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   assign full      = cmd_full || clearing;
   assign accept    = push && !full;
   assign eff_count = (count_ff > COUNT_CAP) ? COUNT_CAP : count_ff;
   assign first_ext = {1'b0, req_first_index};
   assign last_ext  = {1'b0, req_last_index};
   assign last_clip = (last_ext >= eff_count) ? eff_count - 1'b1 : last_ext;

   // Classify the request word into a command.
   always_comb begin
      cmd_push       = 1'b0;
      cmd_data.op    = CMD_ZERO;
      cmd_data.lo    = req_first_index;
      cmd_data.hi    = last_clip[IDX_W-1:0];
      cmd_data.value = req_new_value;
      if (accept) begin
         if (req_type == REQ_SET) begin
            if (first_ext < eff_count) begin
               cmd_push    = 1'b1;
               cmd_data.op = CMD_SET;
            end
         end else begin
            cmd_push = 1'b1;
            if (eff_count != '0 && first_ext <= last_clip) begin
               cmd_data.op = CMD_SUM;
            end
         end
      end
   end

endmodule

@@ hw/rtl/rsput_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range sum tree engine
// Owns the partial-sum memory. Clears it after reset, walks leaf to root for
// a set, walks both range edges upward for a sum, and returns zero for an empty query.
// ----------------------------------------------------------------------------
module rsput_back #(
   parameter int LEAF_COUNT = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               cmd_empty,
   input  rsput_pkg::cmd_type                 cmd_data,
   output logic                               cmd_pop,
   input  logic                               rsp_full,
   output logic                               rsp_push,
   output logic [rsput_pkg::SUM_W-1:0]        rsp_data,
   output logic                               clearing
);
   import rsput_pkg::*;

   localparam int NODES = 2 * LEAF_COUNT;
   localparam int AW    = $clog2(NODES);
   localparam int NW    = $clog2(NODES + 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SET   = 3'd2;
   localparam logic [2:0] ST_SUM_L = 3'd3;
   localparam logic [2:0] ST_SUM_R = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [SUM_W-1:0]        tree_mem_ff [NODES];
   logic [SUM_W-1:0]        rd_data_ff;

   logic [2:0]              state_ff, state_in;
   logic [AW-1:0]           clr_addr_ff, clr_addr_in;
   logic [NW-1:0]           node_l_ff, node_l_in;
   logic [NW-1:0]           node_r_ff, node_r_in;
   logic [SUM_W-1:0]        acc_ff, acc_in;
   logic                    pend_ff, pend_in;
   logic [SUM_W-1:0]        diff_ff, diff_in;
   logic                    first_ff, first_in;
   logic signed [VAL_W-1:0] value_ff, value_in;

   logic [AW-1:0]           rd_addr;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [SUM_W-1:0]        wr_data;

   logic [SUM_W-1:0]        acc_add;
   logic [SUM_W-1:0]        value_ext;
   logic [SUM_W-1:0]        delta;
   logic [NW-1:0]           parent;
   logic [NW-1:0]           r_dec;
   logic [NW-1:0]           leaf_base;

   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_data  = acc_ff;
   assign acc_add   = pend_ff ? acc_ff + rd_data_ff : acc_ff;
   assign value_ext = {{(SUM_W - VAL_W){value_ff[VAL_W-1]}}, value_ff};
   assign delta     = first_ff ? value_ext - rd_data_ff : diff_ff;
   assign parent    = node_l_ff >> 1;
   assign r_dec     = node_r_ff[0] ? node_r_ff - 1'b1 : node_r_ff;
   assign leaf_base = NW'(LEAF_COUNT);

   // Sequencer for clear, set and sum walks.
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      node_l_in   = node_l_ff;
      node_r_in   = node_r_ff;
      acc_in      = acc_ff;
      pend_in     = 1'b0;
      diff_in     = diff_ff;
      first_in    = first_ff;
      value_in    = value_ff;
      rd_addr     = node_l_ff[AW-1:0];
      wr_en       = 1'b0;
      wr_addr     = node_l_ff[AW-1:0];
      wr_data     = '0;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(NODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               acc_in  = '0;
               unique case (cmd_data.op)
                  CMD_SET: begin
                     node_l_in = leaf_base + NW'(cmd_data.lo);
                     rd_addr   = node_l_in[AW-1:0];
                     value_in  = cmd_data.value;
                     first_in  = 1'b1;
                     state_in  = ST_SET;
                  end
                  CMD_SUM: begin
                     node_l_in = leaf_base + NW'(cmd_data.lo);
                     node_r_in = leaf_base + NW'(cmd_data.hi) + 1'b1;
                     state_in  = ST_SUM_L;
                  end
                  default: begin
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_SET: begin
            // Add the difference to this node and fetch its parent.
            wr_en     = 1'b1;
            wr_data   = rd_data_ff + delta;
            diff_in   = delta;
            first_in  = 1'b0;
            node_l_in = parent;
            rd_addr   = parent[AW-1:0];
            if (parent == '0) begin
               state_in = ST_IDLE;
            end
         end
         ST_SUM_L: begin
            // Left edge of one level.
            acc_in = acc_add;
            if (node_l_ff < node_r_ff) begin
               if (node_l_ff[0]) begin
                  rd_addr   = node_l_ff[AW-1:0];
                  pend_in   = 1'b1;
                  node_l_in = node_l_ff + 1'b1;
               end
               state_in = ST_SUM_R;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_SUM_R: begin
            // Right edge of one level, then climb.
            acc_in = acc_add;
            if (node_r_ff[0]) begin
               rd_addr = r_dec[AW-1:0];
               pend_in = 1'b1;
            end
            node_r_in = r_dec >> 1;
            node_l_in = node_l_ff >> 1;
            state_in  = ST_SUM_L;
         end
         ST_OUT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         pend_ff     <= 1'b0;
         first_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         pend_ff     <= pend_in;
         first_ff    <= first_in;
      end
   end

   // Walk registers carry no reset.
   always_ff @(posedge clock) begin
      node_l_ff <= node_l_in;
      node_r_ff <= node_r_in;
      acc_ff    <= acc_in;
      diff_ff   <= diff_in;
      value_ff  <= value_in;
   end

   // Partial-sum memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tree_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= tree_mem_ff[rd_addr];
   end

endmodule

@@ hw/rtl/rsput_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range sum tree port checker
// Watches the top level ports for reset, clearing and result hold behavior.
// ----------------------------------------------------------------------------
`include "range_sum_point_update_tree_unit_macros.svh"

module rsput_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               full,
   input logic                               empty,
   input logic                               pop,
   input logic signed [rsput_pkg::SUM_W-1:0] rsp_range_sum
);
   import rsput_pkg::*;

   // Reset leaves no results and blocks input for the clearing pass.
   `RSPUT_ASSERT_NEXT(a_reset_state, clock, 1'b0, reset, full && empty)

   // The clearing pass holds full high after reset is released.
   `RSPUT_ASSERT_NOW(a_clear_hold, clock, reset, $fell(reset), full ##1 full ##1 full)

   // A result that is not taken stays.
   `RSPUT_ASSERT_NEXT(a_result_held, clock, reset, !empty && !pop, !empty)

   // Its value stays as well.
   `RSPUT_ASSERT_NEXT(a_result_stable, clock, reset, !empty && !pop, $stable(rsp_range_sum))

endmodule

bind range_sum_point_update_tree_unit rsput_checker u_rsput_checker (
   .clock         (clock),
   .reset         (reset),
   .full          (full),
   .empty         (empty),
   .pop           (pop),
   .rsp_range_sum (rsp_range_sum)
);

@@ test/tb_range_sum_point_update_tree_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range sum tree unit testbench
// Drives set and sum request words through the input queue and checks every
// returned sum against a flat array model of the elements. The run covers
// directed corner cases, then random phases under several element counts,
// with random gaps on both sides, one long output stall, and a full drain before each count write.
// ----------------------------------------------------------------------------
module tb_range_sum_point_update_tree_unit;
   import rsput_pkg::*;

   localparam int LEAF_COUNT  = 1024;
   localparam int CLOCK_HALF  = 10;
   localparam int STALL_LIMIT = 20000;
   localparam int LONG_HOLD   = 4000;
   localparam int MAX_REPORTS = 100;

   // One request word as it is offered on the input side.
   typedef struct {
      logic                    kind;
      logic [IDX_W-1:0]        first_idx;
      logic [IDX_W-1:0]        last_idx;
      logic signed [VAL_W-1:0] value;
   } tree_request_type;

   // Tracks the element array and the sums that the block still owes.
   class range_sum_tracker;
      bit [63:0]        element_vals [LEAF_COUNT];
      int unsigned      element_count;
      bit [SUM_W-1:0]   expected_sums [$];
      int               errors;

      function new();
         int i;
         for (i = 0; i < LEAF_COUNT; i++) element_vals[i] = '0;
         element_count = COUNT_RESET;
         errors = 0;
      endfunction

      function void set_count(logic [CNT_W-1:0] count);
         element_count = count;
      endfunction

      function bit idle();
         return expected_sums.size() == 0;
      endfunction

      // Apply an accepted word: a set updates the array, a sum queues its result.
      function void note_request(tree_request_type r);
         int unsigned live;
         int unsigned hi;
         int          i;
         bit [63:0]   acc;
         live = (element_count > LEAF_COUNT) ? LEAF_COUNT : element_count;
         if (r.kind == REQ_SET) begin
            if (r.first_idx < live) element_vals[r.first_idx] = {{32{r.value[31]}}, r.value};
         end else begin
            acc = '0;
            if (live != 0) begin
               hi = (r.last_idx >= live) ? live - 1 : r.last_idx;
               if (r.first_idx <= hi) begin
                  for (i = r.first_idx; i <= hi; i++) acc += element_vals[i];
               end
            end
            expected_sums.push_back(acc[SUM_W-1:0]);
         end
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      task check_sum(logic signed [SUM_W-1:0] got);
         bit [SUM_W-1:0] want;
         if (expected_sums.size() == 0) begin
            report_mismatch($sformatf("range_sum %0d with no sum request waiting", got));
            return;
         end
         want = expected_sums.pop_front();
         if (got !== want)
            report_mismatch($sformatf("range_sum got %0d expected %0d", got, $signed(want)));
      endtask

      task check_leftover();
         if (expected_sums.size() != 0)
            report_mismatch($sformatf("%0d sums never arrived", expected_sums.size()));
      endtask
   endclass

   logic                    clock;
   logic                    reset;
   logic                    push;
   logic                    full;
   logic                    req_type;
   logic [IDX_W-1:0]        req_first_index;
   logic [IDX_W-1:0]        req_last_index;
   logic signed [VAL_W-1:0] req_new_value;
   logic                    empty;
   logic                    pop;
   logic signed [SUM_W-1:0] rsp_range_sum;
   logic                    csr_wr_en;
   logic [CNT_W-1:0]        csr_wr_data;

   range_sum_tracker tracker = new;
   int               sets_since_sum;
   bit               sender_calm;

   range_sum_point_update_tree_unit #(
      .LEAF_COUNT(LEAF_COUNT)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_type       (req_type),
      .req_first_index(req_first_index),
      .req_last_index (req_last_index),
      .req_new_value  (req_new_value),
      .empty          (empty),
      .pop            (pop),
      .rsp_range_sum  (rsp_range_sum),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Mostly short gaps, a few long ones; none at all in a calm stretch.
   function automatic int pick_gap(bit calm);
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 20);
      return $urandom_range(30, 100);
   endfunction

   function automatic tree_request_type mk_req(logic kind, int first_idx, int last_idx,
                                               logic signed [VAL_W-1:0] value);
      tree_request_type r;
      r.kind      = kind;
      r.first_idx = IDX_W'(first_idx);
      r.last_idx  = IDX_W'(last_idx);
      r.value     = value;
      return r;
   endfunction

   // Random word, with indices mostly inside the elements in use.
   function automatic tree_request_type make_request(int unsigned count);
      tree_request_type r;
      int unsigned      live;
      logic [IDX_W-1:0] tmp;
      int               pick;
      live        = (count > LEAF_COUNT) ? LEAF_COUNT : count;
      r.kind      = 1'($urandom_range(0, 1));
      r.first_idx = IDX_W'($urandom_range(0, LEAF_COUNT - 1));
      r.last_idx  = IDX_W'($urandom_range(0, LEAF_COUNT - 1));
      if (live > 0 && $urandom_range(0, 9) < 8) r.first_idx = IDX_W'($urandom_range(0, live - 1));
      if (live > 0 && $urandom_range(0, 9) < 8) r.last_idx = IDX_W'($urandom_range(0, live - 1));
      // Most ranges are ordered; the rest stay empty.
      if (r.kind == REQ_SUM && r.first_idx > r.last_idx && $urandom_range(0, 3) != 0) begin
         tmp         = r.first_idx;
         r.first_idx = r.last_idx;
         r.last_idx  = tmp;
      end
      pick = $urandom_range(0, 7);
      case (pick)
         0:       r.value = 32'sh7fffffff;
         1:       r.value = 32'sh80000000;
         2:       r.value = $signed($urandom_range(0, 20)) - 10;
         default: r.value = $urandom();
      endcase
      return r;
   endfunction

   // Offer one word from a falling edge and return at the falling edge after it is taken.
   task automatic send_item(tree_request_type r);
      int gap;
      gap = pick_gap(sender_calm);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push            <= 1'b1;
      req_type        <= r.kind;
      req_first_index <= r.first_idx;
      req_last_index  <= r.last_idx;
      req_new_value   <= r.value;
      @(posedge clock);
      while (full) @(posedge clock);
      tracker.note_request(r);
      if (r.kind == REQ_SET) sets_since_sum++;
      else sets_since_sum = 0;
      @(negedge clock);
   endtask

   // Stop offering, wait for every owed sum, then let trailing sets finish.
   task automatic drain();
      push <= 1'b0;
      while (!tracker.idle()) @(negedge clock);
      repeat (64 + 20 * sets_since_sum) @(negedge clock);
      sets_since_sum = 0;
   endtask

   task automatic write_count(logic [CNT_W-1:0] count);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      tracker.set_count(count);
   endtask

   // Result side: pop with random stalls, and one long hold so the block backs up.
   initial begin : result_side
      int stall;
      int seen;
      bit calm;
      pop   = 1'b0;
      stall = 0;
      seen  = 0;
      calm  = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (stall > 0) begin
            pop <= 1'b0;
            stall--;
         end else begin
            pop <= 1'b1;
         end
         @(posedge clock);
         if (pop && !empty) begin
            tracker.check_sum(rsp_range_sum);
            seen++;
            if (seen % 64 == 0) calm = ($urandom_range(0, 3) == 0);
            stall = pick_gap(calm);
            if (seen == 60) stall = LONG_HOLD;
         end
         @(negedge clock);
      end
   end

   // Watchdog: ends the run when no word moves on either side for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty)) quiet = 0;
         else quiet++;
         if (quiet == STALL_LIMIT) begin
            $display("Timeout: no word accepted for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Request side: reset, directed words, then random phases.
   initial begin : request_side
      int unsigned phase_counts [9];
      int          phase_items [9];
      int          p;
      int          n;
      phase_counts = '{1024, 16, 1, 0, 2047, 100, 1025, 2, 1000};
      phase_items  = '{200, 150, 60, 30, 150, 150, 100, 50, 50};

      reset           = 1'b1;
      push            = 1'b0;
      req_type        = REQ_SET;
      req_first_index = '0;
      req_last_index  = '0;
      req_new_value   = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      sets_since_sum  = 0;
      sender_calm     = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Reset count of 1024: cleared tree, extreme values at both ends, empty range.
      send_item(mk_req(REQ_SUM, 0, 1023, 0));
      send_item(mk_req(REQ_SET, 0, 0, 32'sh7fffffff));
      send_item(mk_req(REQ_SET, 1023, 0, 32'sh80000000));
      send_item(mk_req(REQ_SET, 512, 1023, -1));
      send_item(mk_req(REQ_SUM, 0, 1023, 0));
      send_item(mk_req(REQ_SUM, 0, 0, 0));
      send_item(mk_req(REQ_SUM, 1023, 1023, 0));
      send_item(mk_req(REQ_SUM, 5, 3, 0));
      send_item(mk_req(REQ_SET, 0, 0, 32'sh80000000));
      send_item(mk_req(REQ_SET, 1, 0, 32'sh80000000));
      send_item(mk_req(REQ_SUM, 0, 1, 0));
      send_item(mk_req(REQ_SUM, 1, 1022, 0));
      send_item(mk_req(REQ_SUM, 1023, 0, 0));

      // Small count: sets past the end are dropped and the query end is clipped.
      write_count(CNT_W'(10));
      send_item(mk_req(REQ_SET, 10, 0, 5));
      send_item(mk_req(REQ_SET, 1023, 0, 7));
      send_item(mk_req(REQ_SUM, 0, 1023, 0));
      send_item(mk_req(REQ_SUM, 12, 1023, 0));
      send_item(mk_req(REQ_SET, 9, 0, 123));
      send_item(mk_req(REQ_SUM, 0, 1023, 0));

      // No element in use: every sum is zero and sets are dropped.
      write_count(CNT_W'(0));
      send_item(mk_req(REQ_SUM, 0, 0, 0));
      send_item(mk_req(REQ_SET, 0, 0, 99));
      send_item(mk_req(REQ_SUM, 0, 1023, 0));

      // A count above the leaf count acts as the full array.
      write_count(CNT_W'(2047));
      send_item(mk_req(REQ_SUM, 0, 1023, 0));

      // Random phases, one per element count; one extra full drain midway.
      for (p = 0; p < 9; p++) begin
         write_count(CNT_W'(phase_counts[p]));
         for (n = 0; n < phase_items[p]; n++) begin
            if (n % 64 == 0) sender_calm = ($urandom_range(0, 3) == 0);
            if (p == 5 && n == 75) drain();
            send_item(make_request(phase_counts[p]));
         end
      end

      drain();
      tracker.check_leftover();
      if (tracker.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
